>>> design/psnd_pkg.sv
// shared constants and types for the point to segment nearest distance block
// no dependencies
package psnd_pkg;

  // default coordinate width, signed q16.16
  localparam int COORD_WIDTH_DEF = 32;

  // bits of the interior fraction t
  localparam int T_FRAC = 32;

  // fraction bits of the q16.16 format
  localparam int Q_FRAC = 16;

  // which point of the segment was nearest
  typedef enum logic [1:0] {
    CASE_START    = 2'd0,
    CASE_END      = 2'd1,
    CASE_INTERIOR = 2'd2
  } near_case_t;

endpackage

>>> design/point_segment_nearest_distance.sv
// nearest point on a 3d segment to a query point, with distance or squared distance
// depends on psnd_pkg
//
// Usage
//   input stream (s_axis): one query per transfer, the query point, the segment start
//   and the segment end packed in tdata, want_squared in tuser
//   output stream (m_axis): one result per query, the nearest point and the distance
//   in tdata, the nearest case code in tuser
//   every stage carries its own valid bit and, unless the receiver stalls, an item
//   may enter in every cycle, so the sustained rate is one query per cycle
//   the pipeline has three stages for the dot products, T_FRAC stages of the
//   one-bit-per-stage divider for the fraction t, five stages for the nearest
//   point and its square distance, COORD_WIDTH+2 stages of the one-bit-per-stage
//   square root and the output register
//   reset clears all valid bits and holds s_axis_tready low; the pipeline holds
//   no other control state
//   when the receiver stalls with a result waiting, the whole pipeline holds and
//   s_axis_tready drops; nothing is lost or repeated
module point_segment_nearest_distance
  import psnd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int IN_DATA_W  = ((9 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // point_x, point_y, point_z, seg_start_x, seg_start_y, seg_start_z,
  // seg_end_x, seg_end_y, seg_end_z
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // want_squared
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // nearest_x, nearest_y, nearest_z, distance_value
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // nearest_case
  output logic [1:0]            m_axis_tuser
);

  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 2;        // signed difference of two coordinates
  localparam int MW  = W + 1;        // magnitude of a difference
  localparam int AW  = 2 * W + 4;    // sum of three squares, also radicand width
  localparam int DTW = AW + 1;       // signed dot product
  localparam int PMW = MW + T_FRAC;  // offset product
  localparam int R   = W + 2;        // root bits
  localparam int RMW = R + 3;        // root remainder

  // whole pipeline advances together
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !rst;

  // stage 1: differences from the segment start
  logic                 st1_vld;
  logic                 st1_want;
  logic signed [W-1:0]  st1_p [3];
  logic signed [W-1:0]  st1_s [3];
  logic signed [W-1:0]  st1_e [3];
  logic signed [DW-1:0] st1_d [3];
  logic signed [DW-1:0] st1_v [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_vld <= 1'b0;
    end else if (en) begin
      st1_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_want <= s_axis_tuser[0];
      for (int i = 0; i < 3; i++) begin
        st1_p[i] <= s_axis_tdata[i*W +: W];
        st1_s[i] <= s_axis_tdata[(3+i)*W +: W];
        st1_e[i] <= s_axis_tdata[(6+i)*W +: W];
        st1_d[i] <= DW'($signed(s_axis_tdata[(6+i)*W +: W]))
                  - DW'($signed(s_axis_tdata[(3+i)*W +: W]));
        st1_v[i] <= DW'($signed(s_axis_tdata[i*W +: W]))
                  - DW'($signed(s_axis_tdata[(3+i)*W +: W]));
      end
    end
  end

  // stage 2: per axis products
  logic                 st2_vld;
  logic                 st2_want;
  logic signed [W-1:0]  st2_p [3];
  logic signed [W-1:0]  st2_s [3];
  logic signed [W-1:0]  st2_e [3];
  logic signed [DW-1:0] st2_d [3];
  logic signed [AW-1:0] st2_vd [3];
  logic        [AW-1:0] st2_dd [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      st2_vld <= 1'b0;
    end else if (en) begin
      st2_vld <= st1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st2_want <= st1_want;
      for (int i = 0; i < 3; i++) begin
        st2_p[i]  <= st1_p[i];
        st2_s[i]  <= st1_s[i];
        st2_e[i]  <= st1_e[i];
        st2_d[i]  <= st1_d[i];
        st2_vd[i] <= AW'(st1_v[i]) * AW'(st1_d[i]);
        st2_dd[i] <= AW'(st1_d[i]) * AW'(st1_d[i]);
      end
    end
  end

  // stage 3: dot and length sums, case decision
  logic signed [DTW-1:0] dot_c;
  logic        [AW-1:0]  len_c;
  near_case_t            code_c;

  always_comb begin
    dot_c = DTW'(st2_vd[0]) + DTW'(st2_vd[1]) + DTW'(st2_vd[2]);
    len_c = st2_dd[0] + st2_dd[1] + st2_dd[2];
    if (dot_c[DTW-1] || dot_c == '0) begin
      code_c = CASE_START;
    end else if (dot_c[AW-1:0] >= len_c) begin
      code_c = CASE_END;
    end else begin
      code_c = CASE_INTERIOR;
    end
  end

  // divider pipeline, index 0 is the stage 3 register
  logic                 dv_vld  [T_FRAC+1];
  logic                 dv_want [T_FRAC+1];
  near_case_t           dv_code [T_FRAC+1];
  logic        [AW-1:0] dv_rem  [T_FRAC+1];
  logic        [AW-1:0] dv_len  [T_FRAC+1];
  logic    [T_FRAC-1:0] dv_tq   [T_FRAC+1];
  logic signed [W-1:0]  dv_p    [T_FRAC+1][3];
  logic signed [W-1:0]  dv_s    [T_FRAC+1][3];
  logic signed [W-1:0]  dv_e    [T_FRAC+1][3];
  logic signed [DW-1:0] dv_d    [T_FRAC+1][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= st2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_want[0] <= st2_want;
      dv_code[0] <= code_c;
      dv_rem[0]  <= dot_c[AW-1:0];
      dv_len[0]  <= len_c;
      dv_tq[0]   <= '0;
      for (int i = 0; i < 3; i++) begin
        dv_p[0][i] <= st2_p[i];
        dv_s[0][i] <= st2_s[i];
        dv_e[0][i] <= st2_e[i];
        dv_d[0][i] <= st2_d[i];
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 1; k <= T_FRAC; k++) begin : g_div
    logic [AW:0] sh;
    logic        ge;

    always_comb begin
      sh = {dv_rem[k-1], 1'b0};
      ge = sh >= {1'b0, dv_len[k-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k] <= 1'b0;
      end else if (en) begin
        dv_vld[k] <= dv_vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_want[k] <= dv_want[k-1];
        dv_code[k] <= dv_code[k-1];
        dv_rem[k]  <= ge ? AW'(sh - {1'b0, dv_len[k-1]}) : sh[AW-1:0];
        dv_len[k]  <= dv_len[k-1];
        dv_tq[k]   <= {dv_tq[k-1][T_FRAC-2:0], ge};
        for (int i = 0; i < 3; i++) begin
          dv_p[k][i] <= dv_p[k-1][i];
          dv_s[k][i] <= dv_s[k-1][i];
          dv_e[k][i] <= dv_e[k-1][i];
          dv_d[k][i] <= dv_d[k-1][i];
        end
      end
    end
  end

  // offset products |d| * t
  logic                 mu_vld;
  logic                 mu_want;
  near_case_t           mu_code;
  logic signed [W-1:0]  mu_p [3];
  logic signed [W-1:0]  mu_s [3];
  logic signed [W-1:0]  mu_e [3];
  logic                 mu_neg [3];
  logic       [PMW-1:0] mu_prod [3];
  logic        [MW-1:0] mag_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = dv_d[T_FRAC][i][DW-1] ? MW'(-dv_d[T_FRAC][i]) : MW'(dv_d[T_FRAC][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_vld <= 1'b0;
    end else if (en) begin
      mu_vld <= dv_vld[T_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mu_want <= dv_want[T_FRAC];
      mu_code <= dv_code[T_FRAC];
      for (int i = 0; i < 3; i++) begin
        mu_p[i]    <= dv_p[T_FRAC][i];
        mu_s[i]    <= dv_s[T_FRAC][i];
        mu_e[i]    <= dv_e[T_FRAC][i];
        mu_neg[i]  <= dv_d[T_FRAC][i][DW-1];
        mu_prod[i] <= PMW'(mag_d[i]) * PMW'(dv_tq[T_FRAC]);
      end
    end
  end

  // nearest point selection with rounded interior offset
  logic                nn_vld;
  logic                nn_want;
  near_case_t          nn_code;
  logic signed [W-1:0] nn_p [3];
  logic signed [W-1:0] nn_n [3];
  logic signed [W-1:0] n_c  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [PMW:0]   rnd;
      logic [MW-1:0]  off;
      logic [DW-1:0]  offs;
      logic [DW-1:0]  nsum;
      rnd  = {1'b0, mu_prod[i]} + ((PMW+1)'(1) << (T_FRAC - 1));
      off  = rnd[T_FRAC +: MW];
      offs = mu_neg[i] ? DW'(-{1'b0, off}) : DW'({1'b0, off});
      nsum = DW'(mu_s[i]) + offs;
      case (mu_code)
        CASE_START:    n_c[i] = mu_s[i];
        CASE_END:      n_c[i] = mu_e[i];
        CASE_INTERIOR: n_c[i] = nsum[W-1:0];
        default:       n_c[i] = mu_s[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nn_vld <= 1'b0;
    end else if (en) begin
      nn_vld <= mu_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nn_want <= mu_want;
      nn_code <= mu_code;
      for (int i = 0; i < 3; i++) begin
        nn_p[i] <= mu_p[i];
        nn_n[i] <= n_c[i];
      end
    end
  end

  // magnitude of nearest minus query
  logic                qd_vld;
  logic                qd_want;
  near_case_t          qd_code;
  logic signed [W-1:0] qd_n [3];
  logic       [MW-1:0] qd_q [3];
  logic signed [DW-1:0] diff_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_c[i] = DW'(nn_n[i]) - DW'(nn_p[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qd_vld <= 1'b0;
    end else if (en) begin
      qd_vld <= nn_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qd_want <= nn_want;
      qd_code <= nn_code;
      for (int i = 0; i < 3; i++) begin
        qd_n[i] <= nn_n[i];
        qd_q[i] <= diff_c[i][DW-1] ? MW'(-diff_c[i]) : MW'(diff_c[i]);
      end
    end
  end

  // squares per axis
  logic                qs_vld;
  logic                qs_want;
  near_case_t          qs_code;
  logic signed [W-1:0] qs_n [3];
  logic [2*MW-1:0]     qs_sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      qs_vld <= 1'b0;
    end else if (en) begin
      qs_vld <= qd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qs_want <= qd_want;
      qs_code <= qd_code;
      for (int i = 0; i < 3; i++) begin
        qs_n[i]  <= qd_n[i];
        qs_sq[i] <= (2*MW)'(qd_q[i]) * (2*MW)'(qd_q[i]);
      end
    end
  end

  // square root pipeline, index 0 holds the squared distance sum
  logic                sr_vld  [R+1];
  logic                sr_want [R+1];
  near_case_t          sr_code [R+1];
  logic [W-1:0]        sr_sqv  [R+1];
  logic signed [W-1:0] sr_n    [R+1][3];
  logic [AW-1:0]       sr_rad  [R+1];
  logic [RMW-1:0]      sr_rem  [R+1];
  logic [R-1:0]        sr_root [R+1];
  logic [AW-1:0]       sum_c;
  logic [AW-Q_FRAC-1:0] sqsh_c;

  always_comb begin
    sum_c  = AW'(qs_sq[0]) + AW'(qs_sq[1]) + AW'(qs_sq[2]);
    sqsh_c = sum_c[AW-1:Q_FRAC];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sr_vld[0] <= 1'b0;
    end else if (en) begin
      sr_vld[0] <= qs_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr_want[0] <= qs_want;
      sr_code[0] <= qs_code;
      sr_sqv[0]  <= (|sqsh_c[AW-Q_FRAC-1:W]) ? '1 : sqsh_c[W-1:0];
      sr_rad[0]  <= sum_c;
      sr_rem[0]  <= '0;
      sr_root[0] <= '0;
      for (int i = 0; i < 3; i++) begin
        sr_n[0][i] <= qs_n[i];
      end
    end
  end

  // digit by digit root, one root bit per stage
  for (genvar j = 1; j <= R; j++) begin : g_sqrt
    logic [RMW-1:0] trial;
    logic [RMW-1:0] nrem;
    logic           ge;

    always_comb begin
      nrem  = {sr_rem[j-1][R:0], sr_rad[j-1][AW-1:AW-2]};
      trial = {1'b0, sr_root[j-1], 2'b01};
      ge    = nrem >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sr_vld[j] <= 1'b0;
      end else if (en) begin
        sr_vld[j] <= sr_vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr_want[j] <= sr_want[j-1];
        sr_code[j] <= sr_code[j-1];
        sr_sqv[j]  <= sr_sqv[j-1];
        sr_rad[j]  <= {sr_rad[j-1][AW-3:0], 2'b00};
        sr_rem[j]  <= ge ? (nrem - trial) : nrem;
        sr_root[j] <= {sr_root[j-1][R-2:0], ge};
        for (int i = 0; i < 3; i++) begin
          sr_n[j][i] <= sr_n[j-1][i];
        end
      end
    end
  end

  // output register, choosing the squared distance or the saturated root
  logic                o_vld;
  logic [W-1:0]        o_dist;
  near_case_t          o_case;
  logic signed [W-1:0] o_n [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= sr_vld[R];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_case <= sr_code[R];
      if (sr_want[R]) begin
        o_dist <= sr_sqv[R];
      end else begin
        o_dist <= (|sr_root[R][R-1:W]) ? '1 : sr_root[R][W-1:0];
      end
      for (int i = 0; i < 3; i++) begin
        o_n[i] <= sr_n[R][i];
      end
    end
  end

  assign m_axis_tvalid = o_vld;
  assign m_axis_tdata  = OUT_DATA_W'({o_dist, o_n[2], o_n[1], o_n[0]});
  assign m_axis_tuser  = o_case;

  // divider remainder stays below the segment length for interior items
  a_div_rem : assert property (@(posedge clk) disable iff (rst)
    dv_vld[T_FRAC] && dv_code[T_FRAC] == CASE_INTERIOR |-> dv_rem[T_FRAC] < dv_len[T_FRAC])
    else $error("divider remainder not below length");

  // root remainder never exceeds twice the root
  a_sqrt_rem : assert property (@(posedge clk) disable iff (rst)
    sr_vld[R] |-> sr_rem[R] <= RMW'({sr_root[R], 1'b0}))
    else $error("square root remainder out of bound");

  // a held output keeps its result while the pipeline is frozen
  a_hold : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(o_vld) && $stable(o_dist) && $stable(o_case))
    else $error("output changed during stall");

endmodule

>>> bench/tb_point_segment_nearest_distance.sv
// testbench for point_segment_nearest_distance: directed table then random queries
// depends on psnd_pkg and point_segment_nearest_distance
`timescale 1ns / 1ps

module tb_point_segment_nearest_distance;
  import psnd_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int IN_W = ((9 * CW + 7) / 8) * 8;
  localparam int OUT_W = ((4 * CW + 7) / 8) * 8;
  localparam int N_RANDOM = 1430;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 2 * CW + T_FRAC + 40;

  typedef struct packed {
    logic [CW-1:0] nx, ny, nz;
    logic [CW-1:0] dist_val;
    near_case_t    ncase;
  } near_result_t;

  typedef struct {
    logic signed [CW-1:0] c [9];
    logic                 sq;
    logic                 has_exp;
    near_result_t         exp;
  } query_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  near_result_t expected_results[$];
  query_row_t   directed_rows[$];
  int  error_count = 0;
  int  idle_cycles = 0;

  always #5 clk = ~clk;

  point_segment_nearest_distance u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // integer square root, floor
  function automatic logic [127:0] isqrt_floor(logic [127:0] x);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  // nearest point, distance and case for one query
  function automatic near_result_t nearest_on_segment(query_row_t q);
    near_result_t res;
    logic signed [127:0] p [3], s [3], d [3], n [3];
    logic signed [127:0] dotv, lenv, off, diff;
    logic [127:0] tq, mg, sq, val;
    dotv = 0;
    lenv = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = q.c[i];
      s[i] = q.c[3 + i];
      d[i] = 128'(signed'(q.c[6 + i])) - s[i];
      dotv += (p[i] - s[i]) * d[i];
      lenv += d[i] * d[i];
    end
    if (dotv <= 0) begin
      res.ncase = CASE_START;
      for (int i = 0; i < 3; i++) n[i] = s[i];
    end else if (dotv >= lenv) begin
      res.ncase = CASE_END;
      for (int i = 0; i < 3; i++) n[i] = 128'(signed'(q.c[6 + i]));
    end else begin
      res.ncase = CASE_INTERIOR;
      // dot < len < 2^66, so the shifted dividend fits in 128 bits
      tq = (128'(dotv) << T_FRAC) / 128'(lenv);
      for (int i = 0; i < 3; i++) begin
        mg = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
        off = signed'((mg * tq + (128'd1 << (T_FRAC - 1))) >> T_FRAC);
        n[i] = s[i] + (d[i] < 0 ? -off : off);
      end
    end
    for (int i = 0; i < 3; i++) begin
      diff = n[i] - p[i];
      sq += 128'(diff * diff);
    end
    val = q.sq ? (sq >> Q_FRAC) : isqrt_floor(sq);
    if (val > {CW{1'b1}}) val = {CW{1'b1}};
    res.nx = n[0][CW-1:0];
    res.ny = n[1][CW-1:0];
    res.nz = n[2][CW-1:0];
    res.dist_val = val[CW-1:0];
    return res;
  endfunction

  function automatic query_row_t make_row(logic signed [CW-1:0] px, py, pz, sx, sy, sz,
                                          ex, ey, ez, logic sq);
    query_row_t r;
    r.c = '{px, py, pz, sx, sy, sz, ex, ey, ez};
    r.sq = sq;
    r.has_exp = 1'b0;
    r.exp = '0;
    return r;
  endfunction

  // coordinate mix: full range, small values and extremes
  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1, 2: return signed'(32'($urandom_range(0, 32'h000fffff)) - 32'h00080000);
      default: return signed'($urandom);
    endcase
  endfunction

  // one input transfer after a random idle gap bounded by max_gap
  task automatic send_query(query_row_t q, int max_gap);
    near_result_t pred;
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pred = nearest_on_segment(q);
    if (q.has_exp && pred !== q.exp) begin
      $display("%0t: table row disagrees with predictor expected %h actual %h",
               $time, q.exp, pred);
      error_count++;
    end
    s_axis_tdata <= {q.c[8], q.c[7], q.c[6], q.c[5], q.c[4], q.c[3], q.c[2], q.c[1], q.c[0]};
    s_axis_tuser <= q.sq;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_results.push_back(q.has_exp ? q.exp : pred);
  endtask

  // result side: random stalls, compare with oldest expectation
  initial begin
    near_result_t got, want;
    int gap;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        got.nx = m_axis_tdata[CW-1:0];
        got.ny = m_axis_tdata[2*CW-1:CW];
        got.nz = m_axis_tdata[3*CW-1:2*CW];
        got.dist_val = m_axis_tdata[4*CW-1:3*CW];
        got.ncase = near_case_t'(m_axis_tuser);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected transfer expected none actual %h", $time, got);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz) begin
            $display("%0t: nearest point mismatch expected %h %h %h actual %h %h %h",
                     $time, want.nx, want.ny, want.nz, got.nx, got.ny, got.nz);
            error_count++;
          end
          if (got.dist_val !== want.dist_val) begin
            $display("%0t: distance mismatch expected %h actual %h", $time, want.dist_val,
                     got.dist_val);
            error_count++;
          end
          if (got.ncase !== want.ncase) begin
            $display("%0t: case mismatch expected %0d actual %0d", $time, want.ncase,
                     got.ncase);
            error_count++;
          end
        end
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
          m_axis_tready <= 1'b1;
        end
      end else if (!m_axis_tready) begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (!rst)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("point_segment_nearest_distance test failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    query_row_t r;
    logic signed [CW-1:0] mx, mn, one;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    one = 32'sh00010000;
    // zero-length segment gives start, distance from origin
    r = make_row(0, 0, 0, one, 0, 0, one, 0, 0, 1'b0);
    r.has_exp = 1'b1;
    r.exp = '{one, 0, 0, 32'h00010000, CASE_START};
    directed_rows.push_back(r);
    // point beyond end, squared distance of one
    r = make_row(2 * one, 0, 0, 0, 0, 0, one, 0, 0, 1'b1);
    r.has_exp = 1'b1;
    r.exp = '{one, 0, 0, 32'h00010000, CASE_END};
    directed_rows.push_back(r);
    // point before start
    r = make_row(-one, 0, 0, 0, 0, 0, one, 0, 0, 1'b0);
    r.has_exp = 1'b1;
    r.exp = '{0, 0, 0, 32'h00010000, CASE_START};
    directed_rows.push_back(r);
    // interior at midpoint
    r = make_row(one, one, 0, 0, 0, 0, 2 * one, 0, 0, 1'b1);
    r.has_exp = 1'b1;
    r.exp = '{one, 0, 0, 32'h00010000, CASE_INTERIOR};
    directed_rows.push_back(r);
    // far corners saturate the distance
    r = make_row(mx, mx, mx, mn, mn, mn, mn, mn, mn, 1'b1);
    r.has_exp = 1'b1;
    r.exp = '{mn, mn, mn, 32'hffffffff, CASE_START};
    directed_rows.push_back(r);
    directed_rows.push_back(make_row(mx, mx, mx, mn, mn, mn, mn, mn, mn, 1'b0));
    // extreme segments, interior and endpoints
    directed_rows.push_back(make_row(0, 0, 0, mn, mn, mn, mx, mx, mx, 1'b0));
    directed_rows.push_back(make_row(0, 0, 0, mn, mn, mn, mx, mx, mx, 1'b1));
    directed_rows.push_back(make_row(mx, 0, mn, mn, mx, 0, mx, mn, mx, 1'b0));
    directed_rows.push_back(make_row(mn, mn, mn, mx, mx, mx, mn, mx, mn, 1'b1));
    directed_rows.push_back(make_row(mx, mx, mx, mx, mx, mx, mx, mx, mx, 1'b1));
    directed_rows.push_back(make_row(-1, -1, -1, 0, 0, 0, 1, 1, 1, 1'b0));
    directed_rows.push_back(make_row(1, 2, 3, 0, 0, 0, 3, -5, 7, 1'b0));
    directed_rows.push_back(make_row(one, 7, -9, -one, 3, 4, 5 * one, -2, 11, 1'b1));
    // exactly at the end point
    directed_rows.push_back(make_row(one, one, one, 0, 0, 0, one, one, one, 1'b0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) send_query(directed_rows[i], 8);
    for (int k = 0; k < N_RANDOM; k++) begin
      r = make_row(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   1'($urandom_range(0, 1)));
      // some back-to-back bursts
      send_query(r, (k % 200 < 30) ? 0 : 8);
    end
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("point_segment_nearest_distance test passed");
    else
      $display("point_segment_nearest_distance test failed");
    $finish;
  end

endmodule
